### rtl/jitter_buffer_playout_tracker_unit_assert.svh
// Assertion macros used by the playout tracker engine.
// Needs clk and rst_n in the scope of every use.
`ifndef JITTER_BUFFER_PLAYOUT_TRACKER_UNIT_ASSERT_SVH
`define JITTER_BUFFER_PLAYOUT_TRACKER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JBPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JBPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JBPT_ASSERT_IMP(lbl, ante, cons, msg)
`define JBPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/jbpt_pkg.sv
// Shared types and constants of the playout tracker.
// No dependencies.
package jbpt_pkg;
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_WEIGHT = 256;
    localparam int WC_W       = $clog2(MAX_WEIGHT) + 1;
    localparam int SPP_W      = 11;
    localparam int SEQ_W      = 16;
    localparam int DIV_W      = 50;
    localparam int DVS_W      = 19;
    localparam int SQ_IN_W    = 56;
    localparam int SQ_OUT_W   = 28;

    localparam logic [SPP_W-1:0] SPP_RESET = 11'd160;
    localparam logic [SPP_W-1:0] SPP_MAX   = 11'd1024;
    localparam logic [WC_W-1:0]  WEIGHT_INIT = WC_W'(4);
    localparam logic [WC_W-1:0]  WEIGHT_MAX  = WC_W'(MAX_WEIGHT);
    localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] Q40_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] Q40_MIN = 40'h80_0000_0000;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] seq;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SQ_OUT_W-1:0] root;
    } sqrt_rsp_t;
endpackage

### rtl/jitter_buffer_playout_tracker_unit.sv
// Top level of the adaptive playout tracker: config register, queue, engine, units.
// Depends on jbpt_pkg, jbpt_queue, jbpt_divider, jbpt_sqrt and jbpt_engine.
//
//  Channel   Direction  Handshake           Contents
//  s_*       in         s_tvalid/s_tready   packet arrival or one playout tick
//  m_*       out        m_tvalid/m_tready   one result per input transaction
//  cfg_*     in         cfg_wr_en           samples_per_packet, no read-back
//
// A tick that does not finish a frame uses neither unit; a frame tick makes one pass
// through the shared divider; a packet makes two divider passes and one pass through
// the square root unit. After reset the slot table is cleared one entry a cycle, all
// 1024 entries, during which s_tready stays low. The two-entry input queue keeps
// taking up to two transactions while a result waits on a stalled master side.
module jitter_buffer_playout_tracker_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [10:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // packet_seq
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // play_seq, present, resync, lost_total,
                                    // discont_total, playout_delay, zero fill
    output logic         m_tuser    // frame_done
);
    import jbpt_pkg::*;

    logic [SPP_W-1:0] spp_reg;
    logic [SPP_W-1:0] spp_eff;
    item_t            in_item;
    item_t            q_item;
    logic             q_valid;
    logic             q_ready;
    logic             clear_busy;
    div_req_t         div_req;
    div_rsp_t         div_rsp;
    sqrt_req_t        sqrt_req;
    sqrt_rsp_t        sqrt_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= SPP_RESET;
        end
        else if (cfg_wr_en)
        begin
            spp_reg <= cfg_wr_data;
        end
    end

    // Zero behaves as one sample per packet, values above 1024 as 1024.
    always_comb
    begin
        priority if (spp_reg == '0)
        begin
            spp_eff = SPP_W'(1);
        end
        else if (spp_reg > SPP_MAX)
        begin
            spp_eff = SPP_MAX;
        end
        else
        begin
            spp_eff = spp_reg;
        end
    end

    assign in_item.kind = s_tuser;
    assign in_item.seq  = s_tdata;

    jbpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!clear_busy),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    jbpt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    jbpt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    jbpt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .spp        (spp_eff),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .clear_busy (clear_busy),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .sqrt_req   (sqrt_req),
        .sqrt_rsp   (sqrt_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );
endmodule

### rtl/jbpt_queue.sv
// Two-entry input queue between the stream slave port and the engine.
// Depends on jbpt_pkg.
module jbpt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enable,
    input  logic           in_valid,
    output logic           in_ready,
    input  jbpt_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output jbpt_pkg::item_t out_item
);
    import jbpt_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = enable && (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

### rtl/jbpt_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on jbpt_pkg.
module jbpt_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  jbpt_pkg::div_req_t req,
    output jbpt_pkg::div_rsp_t rsp
);
    import jbpt_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
            quo_reg  <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

### rtl/jbpt_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on jbpt_pkg.
module jbpt_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  jbpt_pkg::sqrt_req_t req,
    output jbpt_pkg::sqrt_rsp_t rsp
);
    import jbpt_pkg::*;

    localparam int REM_W = SQ_OUT_W + 2;
    localparam int CNT_W = $clog2(SQ_OUT_W);

    logic [SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    rem_sub;
    logic                ge;

    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[SQ_IN_W-1:SQ_IN_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[SQ_OUT_W-2:0], ge};
            rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
            cnt_reg  <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SQ_OUT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

### rtl/jbpt_engine.sv
// Back end of the playout tracker: delay statistics, frame logic, slot table.
// Depends on jbpt_pkg and the assertion macro header.
`include "jitter_buffer_playout_tracker_unit_assert.svh"
module jbpt_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [10:0]         spp,
    input  logic                item_valid,
    output logic                item_ready,
    input  jbpt_pkg::item_t     item,
    output logic                clear_busy,
    output jbpt_pkg::div_req_t  div_req,
    input  jbpt_pkg::div_rsp_t  div_rsp,
    output jbpt_pkg::sqrt_req_t sqrt_req,
    input  jbpt_pkg::sqrt_rsp_t sqrt_rsp,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [119:0]        m_tdata,
    output logic                m_tuser
);
    import jbpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PKT, S_MDIV_GO, S_MDIV_WAIT, S_ERR, S_SQ, S_VDIV_GO, S_VDIV_WAIT,
        S_SQRT_GO, S_SQRT_WAIT, S_QUANT, S_TICK, S_FDIV_GO, S_FDIV_WAIT, S_RD, S_CHK
    } state_t;

    state_t              state_reg;
    logic [SEQ_W-1:0]    slot_mem [SLOTS];
    logic [SEQ_W-1:0]    rd_data_reg;
    logic                clr_busy_reg;
    logic [SLOT_W-1:0]   clr_idx_reg;

    logic [31:0]         play_clock_reg;
    logic [9:0]          phase_reg;
    logic [39:0]         mean_reg;
    logic [47:0]         var_reg;
    logic [WC_W-1:0]     wc_reg;
    logic [39:0]         quant_reg;
    logic [SEQ_W-1:0]    cps_reg;
    logic [31:0]         seen_reg;
    logic [31:0]         lost_reg;
    logic [31:0]         disc_reg;

    logic [SEQ_W-1:0]    seq_reg;
    logic [26:0]         base_reg;
    logic [39:0]         dq_reg;
    logic                neg_reg;
    logic [27:0]         ae_reg;
    logic                big_reg;
    logic [47:0]         sq_reg;
    logic                frame_reg;
    logic                present_reg;
    logic                jump_reg;

    logic                out_valid_reg;
    logic                out_frame_reg;
    logic [113:0]        out_data_reg;

    logic [31:0]         d_u;
    logic [40:0]         mx;
    logic [40:0]         mx_abs;
    logic [41:0]         mmag;
    logic [41:0]         mdelta;
    logic [41:0]         mean_new;
    logic [40:0]         ex;
    logic [40:0]         ex_abs;
    logic [55:0]         prod;
    logic [55:0]         prod_rnd;
    logic [48:0]         vy;
    logic [48:0]         vy_abs;
    logic [49:0]         vmag;
    logic [50:0]         vdelta;
    logic [50:0]         var_new;
    logic [47:0]         var_clamped;
    logic [41:0]         q42;
    logic [39:0]         q_clamped;
    logic [DVS_W-1:0]    per;
    logic [41:0]         t42;
    logic [41:0]         t_abs;
    logic [SEQ_W-1:0]    pot;
    logic [SEQ_W-1:0]    cps_inc;
    logic [SEQ_W-1:0]    diff;
    logic                jump_now;
    logic [10:0]         phase_inc;
    logic [41:0]         rv;
    logic [33:0]         r34;
    logic [31:0]         delay_out;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_addr;
    logic [SEQ_W-1:0]    mem_wdata;

    always_comb
    begin
        d_u      = play_clock_reg - {5'b0, base_reg};
        mx       = {d_u[31], d_u, 8'b0} - {mean_reg[39], mean_reg};
        mx_abs   = mx[40] ? (41'd0 - mx) : mx;
        mmag     = {1'b0, mx_abs} + {33'b0, wc_reg >> 1};
        mdelta   = neg_reg ? (42'd0 - div_rsp.quot[41:0]) : div_rsp.quot[41:0];
        mean_new = {{2{mean_reg[39]}}, mean_reg} + mdelta;

        ex       = {dq_reg[39], dq_reg} - {mean_reg[39], mean_reg};
        ex_abs   = ex[40] ? (41'd0 - ex) : ex;
        prod     = ae_reg * ae_reg;
        prod_rnd = prod + 56'd128;

        vy       = {1'b0, sq_reg} - {1'b0, var_reg};
        vy_abs   = vy[48] ? (49'd0 - vy) : vy;
        vmag     = {1'b0, vy_abs} + {41'b0, wc_reg >> 1};
        vdelta   = neg_reg ? (51'd0 - {1'b0, div_rsp.quot}) : {1'b0, div_rsp.quot};
        var_new  = {3'b0, var_reg} + vdelta;
        if (var_new[50])
        begin
            var_clamped = 48'd0;
        end
        else if (var_new[49:48] != 2'b00)
        begin
            var_clamped = VAR_MAX;
        end
        else
        begin
            var_clamped = var_new[47:0];
        end

        q42 = {{2{mean_reg[39]}}, mean_reg} + {13'b0, sqrt_rsp.root, 1'b0}
            + {14'b0, sqrt_rsp.root} + 42'd256;
        if (q42[41:39] == 3'b000 || q42[41:39] == 3'b111)
        begin
            q_clamped = q42[39:0];
        end
        else
        begin
            q_clamped = q42[41] ? Q40_MIN : Q40_MAX;
        end

        per      = {spp, 8'b0};
        t42      = {2'b0, play_clock_reg, 8'b0} - {{2{quant_reg[39]}}, quant_reg}
                 - {23'b0, per};
        t_abs    = t42[41] ? (42'd0 - t42) : t42;
        pot      = neg_reg ? (16'd0 - div_rsp.quot[15:0]) : div_rsp.quot[15:0];
        cps_inc  = cps_reg + 16'd1;
        diff     = cps_inc - pot;
        jump_now = !(diff == 16'd0 || diff == 16'd1 || diff == 16'hFFFF);
        phase_inc = {1'b0, phase_reg} + 11'd1;

        // Round to the nearest sample, halves upward, then clamp to 32 bits.
        rv  = {{2{quant_reg[39]}}, quant_reg} + 42'd128;
        r34 = rv[41:8];
        if (r34[33:31] == 3'b000 || r34[33:31] == 3'b111)
        begin
            delay_out = r34[31:0];
        end
        else
        begin
            delay_out = r34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    assign item_ready = (state_reg == S_IDLE) && !clr_busy_reg && !out_valid_reg;
    assign clear_busy = clr_busy_reg;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {8'b0, mmag};
        div_req.divisor  = {{(DVS_W-WC_W){1'b0}}, wc_reg};
        unique case (state_reg)
            S_MDIV_GO:
            begin
                div_req.start = 1'b1;
            end
            S_VDIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = vmag;
            end
            S_FDIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {8'b0, t_abs};
                div_req.divisor  = per;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
        sqrt_req.start    = (state_reg == S_SQRT_GO);
        sqrt_req.radicand = {var_reg, 8'b0};
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = clr_idx_reg;
        mem_wdata = '0;
        if (clr_busy_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_PKT)
        begin
            mem_we    = 1'b1;
            mem_addr  = seq_reg[SLOT_W-1:0];
            mem_wdata = seq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= slot_mem[cps_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clr_busy_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            play_clock_reg <= '0;
            phase_reg      <= '0;
            mean_reg       <= '0;
            var_reg        <= '0;
            wc_reg         <= WEIGHT_INIT;
            quant_reg      <= '0;
            cps_reg        <= '0;
            seen_reg       <= '0;
            lost_reg       <= '0;
            disc_reg       <= '0;
            seq_reg        <= '0;
            base_reg       <= '0;
            dq_reg         <= '0;
            neg_reg        <= 1'b0;
            ae_reg         <= '0;
            big_reg        <= 1'b0;
            sq_reg         <= '0;
            frame_reg      <= 1'b0;
            present_reg    <= 1'b0;
            jump_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_frame_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid && item_ready)
                    begin
                        seq_reg     <= item.seq;
                        base_reg    <= 27'(item.seq) * 27'(spp);
                        frame_reg   <= 1'b0;
                        present_reg <= 1'b0;
                        jump_reg    <= 1'b0;
                        state_reg   <= (item.kind == KIND_PACKET) ? S_PKT : S_TICK;
                    end
                end
                S_PKT:
                begin
                    if (seen_reg == 32'd0)
                    begin
                        mean_reg       <= '0;
                        var_reg        <= '0;
                        play_clock_reg <= {5'b0, base_reg};
                        wc_reg         <= WEIGHT_INIT;
                    end
                    if (seen_reg != 32'hFFFF_FFFF)
                    begin
                        seen_reg <= seen_reg + 32'd1;
                    end
                    state_reg <= S_MDIV_GO;
                end
                S_MDIV_GO:
                begin
                    dq_reg    <= {d_u, 8'b0};
                    neg_reg   <= mx[40];
                    state_reg <= S_MDIV_WAIT;
                end
                S_MDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= mean_new[39:0];
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    ae_reg    <= ex_abs[27:0];
                    big_reg   <= (ex_abs[40:28] != 13'd0);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq_reg    <= big_reg ? VAR_MAX : prod_rnd[55:8];
                    state_reg <= S_VDIV_GO;
                end
                S_VDIV_GO:
                begin
                    neg_reg   <= vy[48];
                    state_reg <= S_VDIV_WAIT;
                end
                S_VDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        var_reg <= var_clamped;
                        if (wc_reg < WEIGHT_MAX)
                        begin
                            wc_reg <= wc_reg + WC_W'(1);
                        end
                        state_reg <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sqrt_rsp.done)
                    begin
                        state_reg <= S_QUANT;
                    end
                end
                S_QUANT:
                begin
                    quant_reg <= q_clamped;
                    state_reg <= S_CHK;
                end
                S_TICK:
                begin
                    play_clock_reg <= play_clock_reg + 32'd1;
                    if (phase_inc >= spp)
                    begin
                        phase_reg <= '0;
                        frame_reg <= 1'b1;
                        state_reg <= S_FDIV_GO;
                    end
                    else
                    begin
                        phase_reg <= phase_inc[9:0];
                        state_reg <= S_CHK;
                    end
                end
                S_FDIV_GO:
                begin
                    neg_reg   <= t42[41];
                    state_reg <= S_FDIV_WAIT;
                end
                S_FDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (jump_now)
                        begin
                            cps_reg  <= pot;
                            jump_reg <= 1'b1;
                            if (disc_reg != 32'hFFFF_FFFF)
                            begin
                                disc_reg <= disc_reg + 32'd1;
                            end
                        end
                        else
                        begin
                            cps_reg <= cps_inc;
                        end
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    // Frames check the slot read; packets and plain ticks only report.
                    if (frame_reg && !present_reg && rd_data_reg == cps_reg)
                    begin
                        present_reg <= 1'b1;
                    end
                    if (frame_reg && rd_data_reg != cps_reg && lost_reg != 32'hFFFF_FFFF)
                    begin
                        lost_reg <= lost_reg + 32'd1;
                    end
                    if (frame_reg && rd_data_reg != cps_reg)
                    begin
                        out_data_reg <= {delay_out, disc_reg, lost_reg + 32'(lost_reg != 32'hFFFF_FFFF),
                                         jump_reg, 1'b0, cps_reg};
                    end
                    else
                    begin
                        out_data_reg <= {delay_out, disc_reg, lost_reg, jump_reg,
                                         frame_reg, cps_reg};
                    end
                    out_frame_reg <= frame_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_frame_reg;
    assign m_tdata  = {6'b0, out_data_reg};

    `JBPT_ASSERT_IMP(a_flags_need_frame, out_valid_reg && !out_frame_reg, !out_data_reg[16] && !out_data_reg[17], "present or resync without a frame")
    `JBPT_ASSERT_IMP(a_div_not_busy, div_req.start, !div_rsp.busy, "divider started while busy")
    `JBPT_ASSERT_IMP(a_clear_idle, clr_busy_reg, state_reg == S_IDLE && !item_ready, "item taken during slot clearing")
    `JBPT_ASSERT_NXT(a_result_once, state_reg == S_CHK, out_valid_reg && state_reg == S_IDLE, "result not posted")
endmodule
